// ===== sv/cva_pkg.sv =====
// Shared types, widths and the arctangent table of the CORDIC vectoring core.
// Depends on nothing; every other file imports it.
`default_nettype none

package cva_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ITERATIONS  = 15;
    localparam int SCALE_SHIFT = 10;
    // Headroom for the vector growth of the iterations (gain below 1.65 times sqrt 2).
    localparam int GUARD_BITS  = 3;
    localparam int WORK_WIDTH  = COORD_WIDTH + SCALE_SHIFT + GUARD_BITS;
    localparam int ATAN_DEPTH  = 15;
    localparam int ANGLE_LIMIT = 25570;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COORD_WIDTH:0]   t_coord_ext;
    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [WORK_WIDTH-1:0]  t_work;

    // Angles are in units of 1/256 degree.
    localparam t_angle ANGLE_ZERO = t_angle'(0);
    localparam t_angle ANGLE_P90  = t_angle'(23040);
    localparam t_angle ANGLE_M90  = t_angle'(-23040);
    localparam t_angle ANGLE_P45  = t_angle'(11520);
    localparam t_angle ANGLE_M45  = t_angle'(-11520);

    localparam t_angle ATAN_TAB [ATAN_DEPTH] = '{
        t_angle'(11520), t_angle'(6801), t_angle'(3593), t_angle'(1824),
        t_angle'(916),   t_angle'(458),  t_angle'(229),  t_angle'(115),
        t_angle'(57),    t_angle'(29),   t_angle'(14),   t_angle'(7),
        t_angle'(4),     t_angle'(2),    t_angle'(1)
    };

endpackage

`default_nettype wire

// ===== sv/cva_in_if.sv =====
// Input channel of the CORDIC vectoring core: one vector word per handshake.
// Depends on cva_pkg for the coordinate type.
`default_nettype none

interface cva_in_if import cva_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord vec_y;
    t_coord vec_x;

    modport source (output valid, output vec_y, output vec_x, input ready);
    modport sink   (input valid, input vec_y, input vec_x, output ready);
endinterface

`default_nettype wire

// ===== sv/cva_out_if.sv =====
// Output channel of the CORDIC vectoring core: one angle word per handshake.
// Depends on cva_pkg for the angle type.
`default_nettype none

interface cva_out_if import cva_pkg::*;;
    logic   valid;
    logic   ready;
    t_angle angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

// ===== sv/cordic_vectoring_arctangent_core.sv =====
// CORDIC vectoring arctangent core: vector (y, x) in, angle in 1/256 degree out.
// Depends on cva_pkg, cva_in_if and cva_out_if.
//
//   Channel   Dir   Interface    Payload
//   i_vec     in    cva_in_if    vec_y, vec_x (16 bit signed each)
//   o_ang     out   cva_out_if   angle (16 bit signed, 1/256 degree)
//
// Every cycle one vector word can enter unless the pipe is full behind a stalled
// output. The word is registered into stage 0, then passes one CORDIC iteration
// per stage through ITERATIONS stages and lands in the result register. Each
// stage holds its own valid bit and loads whenever it is empty or its successor
// moves, so a stalled output only halts the stages behind it and bubbles still
// fill. Synchronous active-low reset clears the valid bits only; the datapath
// registers carry no reset.
`default_nettype none

module cordic_vectoring_arctangent_core import cva_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cva_in_if.sink      i_vec,
    cva_out_if.source   o_ang
);

    localparam int LAST = ITERATIONS;

    // Pipeline state: stage k holds the vector after k iterations.
    t_work  r_y   [0:LAST];
    t_work  r_x   [0:LAST];
    t_angle r_sum [0:LAST];
    logic   r_vld [0:LAST];

    t_angle r_out_ang;
    logic   r_out_vld;

    // Stage k may load when it is empty or its content moves on this edge.
    logic   w_rdy [0:LAST+1];

    assign w_rdy[LAST+1] = !r_out_vld || o_ang.ready;

    for (genvar k = 0; k <= LAST; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign i_vec.ready = w_rdy[0];

    // Stage 0: special vectors are resolved here. A special vector enters the
    // iterations with y forced to zero, so every later stage passes it
    // unchanged and its preset angle comes out as the result.
    t_coord_ext w_diag_sum;
    t_work      n_y0;
    t_work      n_x0;
    t_angle     n_sum0;

    assign w_diag_sum = t_coord_ext'(i_vec.vec_x) + t_coord_ext'(i_vec.vec_y);

    always_comb begin
        n_y0   = '0;
        n_x0   = '0;
        n_sum0 = ANGLE_ZERO;
        if (i_vec.vec_x == '0) begin
            if (i_vec.vec_y == '0) begin
                n_sum0 = ANGLE_ZERO;
            end else if (i_vec.vec_y[COORD_WIDTH-1]) begin
                n_sum0 = ANGLE_M90;
            end else begin
                n_sum0 = ANGLE_P90;
            end
        end else if (i_vec.vec_y == '0) begin
            n_sum0 = ANGLE_ZERO;
        end else if (i_vec.vec_x == i_vec.vec_y) begin
            n_sum0 = ANGLE_P45;
        end else if (w_diag_sum == '0) begin
            n_sum0 = ANGLE_M45;
        end else begin
            // Scale both coordinates up by 2^SCALE_SHIFT.
            n_y0 = {{GUARD_BITS{i_vec.vec_y[COORD_WIDTH-1]}}, i_vec.vec_y,
                    {SCALE_SHIFT{1'b0}}};
            n_x0 = {{GUARD_BITS{i_vec.vec_x[COORD_WIDTH-1]}}, i_vec.vec_x,
                    {SCALE_SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_vld[0] <= i_vec.valid;
        end
        if (w_rdy[0] && i_vec.valid) begin
            r_y[0]   <= n_y0;
            r_x[0]   <= n_x0;
            r_sum[0] <= n_sum0;
        end
    end

    // Iteration stages. Stage k+1 applies iteration k with a fixed arithmetic
    // shift of k bits; a vector whose y is already zero passes untouched.
    for (genvar k = 0; k < LAST; k++) begin : g_iter
        t_work  n_y;
        t_work  n_x;
        t_angle n_sum;

        always_comb begin
            n_y   = r_y[k];
            n_x   = r_x[k];
            n_sum = r_sum[k];
            if (r_y[k] > 0) begin
                n_x   = r_x[k] + (r_y[k] >>> k);
                n_y   = r_y[k] - (r_x[k] >>> k);
                n_sum = r_sum[k] + ATAN_TAB[k];
            end else if (r_y[k] < 0) begin
                n_x   = r_x[k] - (r_y[k] >>> k);
                n_y   = r_y[k] + (r_x[k] >>> k);
                n_sum = r_sum[k] - ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_rdy[k+1]) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (w_rdy[k+1] && r_vld[k]) begin
                r_y[k+1]   <= n_y;
                r_x[k+1]   <= n_x;
                r_sum[k+1] <= n_sum;
            end
        end
    end

    // Result register: takes the accumulated angle of the last stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy[LAST+1]) begin
            r_out_vld <= r_vld[LAST];
        end
        if (w_rdy[LAST+1] && r_vld[LAST]) begin
            r_out_ang <= r_sum[LAST];
        end
    end

    assign o_ang.valid = r_out_vld;
    assign o_ang.angle = r_out_ang;

    // A word never arrives in the result register without one in the last stage.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !$past(r_out_vld)) |-> $past(r_vld[LAST]))
        else $error("result appeared without a word in the last stage");

    // With the result register empty the whole pipe can move, so input is open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_vec.ready)
        else $error("input blocked while the result register is empty");

    // A word in the last stage is kept while the result register cannot take it.
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && !w_rdy[LAST+1]) |=> r_vld[LAST])
        else $error("word lost from the last stage during a stall");

    // The table sum and the preset angles stay within the documented range.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_ang <= t_angle'(ANGLE_LIMIT))
                   && (r_out_ang >= -t_angle'(ANGLE_LIMIT)))
        else $error("angle out of range");

endmodule

`default_nettype wire

// ===== dv/tb_cordic_vectoring_arctangent_core.sv =====
// Self-checking testbench for the CORDIC vectoring arctangent core.
// Depends on cva_pkg, cva_in_if, cva_out_if and cordic_vectoring_arctangent_core.
// It drives directed and random vector words and checks every angle word against its own predictor.
`default_nettype none

module tb_cordic_vectoring_arctangent_core import cva_pkg::*;;

    // Pipeline depth of the core: one register per iteration plus
    // the input and result registers. It sets the tail wait after the last result.
    localparam int PIPE_LATENCY  = 17;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int DRAIN_LIMIT   = 50000;

    // The scoreboard holds the angles that are still owed by the core, oldest first.
    // Each accepted vector word is turned into its angle right away; each angle word
    // the core delivers is compared against the head of the queue.
    class angle_scoreboard;
        t_angle expected_angles[$];
        int     vectors_in;
        int     angles_checked;
        int     shortcut_hits;
        int     mismatches;

        // Arctangent of 2^-i in 1/256 degree, i = 0 .. 14.
        function int arctan_step(int i);
            case (i)
                0:  return 11520;
                1:  return 6801;
                2:  return 3593;
                3:  return 1824;
                4:  return 916;
                5:  return 458;
                6:  return 229;
                7:  return 115;
                8:  return 57;
                9:  return 29;
                10: return 14;
                11: return 7;
                12: return 4;
                13: return 2;
                default: return 1;
            endcase
        endfunction

        // Angle of (y, x). The axes and both diagonals are answered directly, in that
        // order. Everything else is scaled by 2^10 and walked through 15 vectoring
        // steps; a step that finds y exactly zero changes nothing. Negative x goes
        // through the same walk, so the answer there is not a true quadrant angle.
        function t_angle cordic_angle(t_coord y_in, t_coord x_in);
            longint y, x, nx, ny, acc;
            y   = y_in;
            x   = x_in;
            acc = 0;
            if (x == 0 && y == 0) return t_angle'(0);
            if (x == 0)           return (y < 0) ? t_angle'(-23040) : t_angle'(23040);
            if (y == 0)           return t_angle'(0);
            if (x == y)           return t_angle'(11520);
            if (x == -y)          return t_angle'(-11520);
            y = y * 1024;
            x = x * 1024;
            for (int i = 0; i < 15; i++) begin
                if (y != 0) begin
                    if (y > 0) begin
                        nx  = x + (y >>> i);
                        ny  = y - (x >>> i);
                        acc = acc + arctan_step(i);
                    end else begin
                        nx  = x - (y >>> i);
                        ny  = y + (x >>> i);
                        acc = acc - arctan_step(i);
                    end
                    x = nx;
                    y = ny;
                end
            end
            return t_angle'(acc);
        endfunction

        function void note_vector(t_coord y, t_coord x);
            longint ly, lx;
            ly = y;
            lx = x;
            if (lx == 0 || ly == 0 || lx == ly || lx == -ly) shortcut_hits++;
            vectors_in++;
            expected_angles.push_back(cordic_angle(y, x));
        endfunction

        function void check_angle(t_angle got);
            t_angle want;
            if (expected_angles.size() == 0) begin
                $error("angle word 0x%04h arrived with no vector outstanding", got);
                mismatches++;
                return;
            end
            want = expected_angles.pop_front();
            angles_checked++;
            if (got !== want) begin
                $error("angle: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cva_in_if  vec_if();
    cva_out_if ang_if();

    cordic_vectoring_arctangent_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_if),
        .o_ang   (ang_if)
    );

    angle_scoreboard angle_board = new;

    // When set, the vector side sends without gaps for a stretch of words.
    bit back_to_back;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord extreme_coord();
        case ($urandom_range(0, 6))
            0:       return t_coord'(-32768);
            1:       return t_coord'(-32767);
            2:       return t_coord'(-1);
            3:       return t_coord'(0);
            4:       return t_coord'(1);
            5:       return t_coord'(32766);
            default: return t_coord'(32767);
        endcase
    endfunction

    // Presents one vector word from a falling edge, holds it until a rising edge sees
    // ready, and returns at the next falling edge. Valid stays high into the next call
    // when that call draws no gap, so back-to-back words never drop valid.
    task automatic send_vector(input t_coord y, input t_coord x);
        int gap;
        gap = back_to_back ? 0 : idle_len();
        if (gap > 0) begin
            vec_if.valid = 1'b0;
            vec_if.vec_y = t_coord'($urandom);
            vec_if.vec_x = t_coord'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        vec_if.valid = 1'b1;
        vec_if.vec_y = y;
        vec_if.vec_x = x;
        @(posedge i_clk);
        while (!vec_if.ready) @(posedge i_clk);
        angle_board.note_vector(y, x);
        @(negedge i_clk);
    endtask

    // Result side back-pressure: runs of ready high, usually short and sometimes long,
    // broken by stalls drawn from the same idle distribution.
    initial begin
        ang_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int open_len;
            int shut_len;
            open_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
            shut_len = idle_len();
            ang_if.ready = 1'b1;
            repeat (open_len) @(negedge i_clk);
            if (shut_len > 0) begin
                ang_if.ready = 1'b0;
                repeat (shut_len) @(negedge i_clk);
            end
        end
    end

    // Every angle word taken at a rising edge goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && ang_if.valid && ang_if.ready) angle_board.check_angle(ang_if.angle);
    end

    initial begin
        t_coord ry;
        t_coord rx;
        int     drain_wait;

        vec_if.valid = 1'b0;
        vec_if.vec_y = '0;
        vec_if.vec_x = '0;
        back_to_back = 1'b0;
        i_rst_n      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: the origin, both axes at their extremes, both diagonals in
        // every sign combination, the most negative coordinate, negative x off the
        // shortcuts, and small vectors that drive y to zero partway through the walk.
        send_vector(t_coord'(0), t_coord'(0));
        send_vector(t_coord'(32767), t_coord'(0));
        send_vector(t_coord'(-32768), t_coord'(0));
        send_vector(t_coord'(1), t_coord'(0));
        send_vector(t_coord'(0), t_coord'(32767));
        send_vector(t_coord'(0), t_coord'(-32768));
        send_vector(t_coord'(5), t_coord'(5));
        send_vector(t_coord'(-32768), t_coord'(-32768));
        send_vector(t_coord'(32767), t_coord'(32767));
        send_vector(t_coord'(100), t_coord'(-100));
        send_vector(t_coord'(-32767), t_coord'(32767));
        send_vector(t_coord'(32767), t_coord'(-32767));
        send_vector(t_coord'(-32768), t_coord'(32767));
        send_vector(t_coord'(32767), t_coord'(-32768));
        send_vector(t_coord'(1), t_coord'(32767));
        send_vector(t_coord'(32767), t_coord'(1));
        send_vector(t_coord'(-1), t_coord'(-32768));
        send_vector(t_coord'(-32768), t_coord'(-1));
        send_vector(t_coord'(1000), t_coord'(-3000));
        send_vector(t_coord'(-2500), t_coord'(-700));
        send_vector(t_coord'(3), t_coord'(4));
        send_vector(t_coord'(1), t_coord'(2));
        send_vector(t_coord'(-1), t_coord'(3));

        // Random words: mostly full range, with shares aimed at the shortcuts, at the
        // extreme codes and at tiny vectors where y often lands on zero mid-walk.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
            rx = t_coord'($urandom);
            ry = t_coord'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    ry = t_coord'(int'($urandom_range(0, 16)) - 8);
                    rx = t_coord'(int'($urandom_range(0, 16)) - 8);
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0:       rx = '0;
                        1:       ry = '0;
                        2:       ry = rx;
                        default: ry = t_coord'(-rx);
                    endcase
                end
                2: ry = extreme_coord();
                3: rx = extreme_coord();
                default: ;
            endcase
            send_vector(ry, rx);
        end
        vec_if.valid = 1'b0;

        drain_wait = 0;
        while (angle_board.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (angle_board.pending() != 0)
            $error("%0d angle words never arrived", angle_board.pending());

        $display("Drove %0d vector words (%0d on an axis or diagonal), checked %0d angles.",
                 angle_board.vectors_in, angle_board.shortcut_hits,
                 angle_board.angles_checked);
        $display("Random idling on the input and random stalls on the output were applied.");
        if (angle_board.mismatches == 0 && angle_board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog far above the slowest legal run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/cva_pkg.sv
sv/cva_in_if.sv
sv/cva_out_if.sv
sv/cordic_vectoring_arctangent_core.sv
dv/tb_cordic_vectoring_arctangent_core.sv
